/* hdl/mrfp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrfp_pkg
// Types and constants for the MQTT response frame parser.
// ----------------------------------------------------------------------------
package mrfp_pkg;

    localparam logic [7:0] CH_MARKER   = 8'h3A;
    localparam logic [7:0] T_PINGRESP  = 8'hD0;
    localparam logic [7:0] T_CONNACK   = 8'h20;
    localparam logic [7:0] T_PUBLISH   = 8'h30;
    localparam logic [7:0] T_PUBACK    = 8'h40;
    localparam logic [7:0] T_SUBACK    = 8'h90;
    localparam logic [7:0] CH_O        = 8'h4F;
    localparam logic [7:0] CH_K        = 8'h4B;
    localparam int unsigned MAX_PAYLOAD = 30;

    typedef enum logic [2:0] {
        EV_OK_REPLY = 3'd0,
        EV_PINGRESP = 3'd1,
        EV_CONNACK  = 3'd2,
        EV_PUBACK   = 3'd3,
        EV_SUBACK   = 3'd4,
        EV_PUB_BYTE = 3'd5
    } event_t;

    typedef enum logic [2:0] {
        ST_IDLE     = 3'd0,
        ST_GOT_O    = 3'd1,
        ST_GOT_MARK = 3'd2,
        ST_WAIT_LEN = 3'd3,
        ST_PAYLOAD  = 3'd4,
        ST_REPLAY   = 3'd5
    } state_t;

    typedef struct packed {
        event_t     event_res;
        logic [7:0] data_byte;
        logic       last;
        logic       truncated;
    } res_t;

    function automatic res_t single_event(input event_t ev);
        res_t r;
        r.event_res = ev;
        r.data_byte = 8'h00;
        r.last      = 1'b1;
        r.truncated = 1'b0;
        return r;
    endfunction

endpackage

/* hdl/mrfp_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrfp_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mrfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/mqtt_response_frame_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqtt_response_frame_parser
// Byte-wise parser for the OK link reply and MQTT fixed-header responses,
// with a packet store that replays publish frames.
// ----------------------------------------------------------------------------
// One received byte is taken per cycle whenever no replay is running and the
// result register is free or being emptied. Acks, ping responses and the OK
// reply give one result on the cycle after their final byte. A publish frame is
// kept in a packet RAM (type, length, up to PACKET_BYTES-2 but at most 30
// payload bytes) and on its final byte is replayed, type and length bytes
// included, from that RAM's single read port: a first read is started, then
// one result per cycle while m_ready is high, and input is held off until
// the last byte is given. The RAM is not cleared after reset; only entries
// written by the current frame are read.
module mqtt_response_frame_parser #(
    parameter int PACKET_BYTES = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic [7:0]              s_rx_byte,
    input  logic                    s_mqtt_mode,
    input  logic                    s_valid,
    output logic                    s_ready,
    output mrfp_pkg::event_t        m_event_res,
    output logic [7:0]              m_data_byte,
    output logic                    m_last,
    output logic                    m_truncated,
    output logic                    m_valid,
    input  logic                    m_ready
);
    import mrfp_pkg::*;

    localparam int AW = $clog2(PACKET_BYTES);
    localparam int PAYLOAD_CAP =
        ((PACKET_BYTES - 2) < MAX_PAYLOAD) ? (PACKET_BYTES - 2) : MAX_PAYLOAD;

    state_t         state_reg, state_next;
    logic [7:0]     type_reg, type_next;
    logic [7:0]     count_reg, count_next;
    logic [7:0]     length_reg, length_next;
    logic           overflow_reg, overflow_next;
    logic [AW-1:0]  data_idx_reg, data_idx_next;
    logic [AW-1:0]  last_idx_reg, last_idx_next;
    logic           rd_pending_reg, rd_pending_next;
    logic           m_valid_reg, m_valid_next;
    res_t           res_reg, res_next;

    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    logic           rd_en;
    logic [AW-1:0]  rd_addr;
    logic [7:0]     rd_data;

    logic           out_free;
    logic           accept;
    logic           finish;
    logic [7:0]     count_inc;
    logic [7:0]     len_now;
    logic [7:0]     stored;
    logic           is_last;

    mrfp_ram #(
        .WIDTH (8),
        .DEPTH (PACKET_BYTES)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_rx_byte),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            length_reg     <= '0;
            overflow_reg   <= 1'b0;
            rd_pending_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            length_reg     <= length_next;
            overflow_reg   <= overflow_next;
            rd_pending_reg <= rd_pending_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        type_reg     <= type_next;
        data_idx_reg <= data_idx_next;
        last_idx_reg <= last_idx_next;
        res_reg      <= res_next;
    end

    always_comb begin
        state_next      = state_reg;
        type_next       = type_reg;
        count_next      = count_reg;
        length_next     = length_reg;
        overflow_next   = overflow_reg;
        data_idx_next   = data_idx_reg;
        last_idx_next   = last_idx_reg;
        rd_pending_next = rd_pending_reg;
        res_next        = res_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        wr_en           = 1'b0;
        wr_addr         = '0;
        rd_en           = 1'b0;
        rd_addr         = data_idx_reg;
        finish          = 1'b0;

        out_free  = !m_valid_reg || m_ready;
        s_ready   = (state_reg != ST_REPLAY) && out_free;
        accept    = s_valid && s_ready;
        count_inc = count_reg + 8'd1;
        len_now   = (state_reg == ST_WAIT_LEN) ? s_rx_byte : length_reg;
        stored    = (len_now > 8'(PAYLOAD_CAP)) ? 8'(PAYLOAD_CAP) : len_now;
        is_last   = (data_idx_reg == last_idx_reg);

        case (state_reg)
            ST_REPLAY: begin
                if (!rd_pending_reg) begin
                    rd_en           = 1'b1;
                    rd_pending_next = 1'b1;
                end else if (out_free) begin
                    res_next.event_res = EV_PUB_BYTE;
                    res_next.data_byte = rd_data;
                    res_next.last      = is_last;
                    res_next.truncated = overflow_reg;
                    m_valid_next       = 1'b1;
                    if (is_last) begin
                        state_next      = ST_IDLE;
                        rd_pending_next = 1'b0;
                    end else begin
                        rd_en         = 1'b1;
                        rd_addr       = data_idx_reg + AW'(1);
                        data_idx_next = data_idx_reg + AW'(1);
                    end
                end
            end
            ST_GOT_O: begin
                if (accept) begin
                    state_next = ST_IDLE;
                    if (s_rx_byte == CH_K) begin
                        res_next     = single_event(EV_OK_REPLY);
                        m_valid_next = 1'b1;
                    end
                end
            end
            ST_GOT_MARK: begin
                if (accept) begin
                    state_next = ST_IDLE;
                    if (s_rx_byte == T_PINGRESP) begin
                        res_next     = single_event(EV_PINGRESP);
                        m_valid_next = 1'b1;
                    end else if (s_rx_byte inside {T_CONNACK, T_PUBLISH, T_PUBACK,
                                                   T_SUBACK}) begin
                        wr_en      = 1'b1;
                        wr_addr    = AW'(0);
                        type_next  = s_rx_byte;
                        state_next = ST_WAIT_LEN;
                    end
                end
            end
            ST_WAIT_LEN: begin
                if (accept) begin
                    wr_en         = 1'b1;
                    wr_addr       = AW'(1);
                    length_next   = s_rx_byte;
                    count_next    = '0;
                    overflow_next = 1'b0;
                    if (s_rx_byte == 8'd0) begin
                        finish = 1'b1;
                    end else begin
                        state_next = ST_PAYLOAD;
                    end
                end
            end
            ST_PAYLOAD: begin
                if (accept) begin
                    if (count_reg < 8'(PAYLOAD_CAP)) begin
                        wr_en   = 1'b1;
                        wr_addr = AW'({1'b0, count_reg} + 9'd2);
                    end else begin
                        overflow_next = 1'b1;
                    end
                    count_next = count_inc;
                    if (count_inc == length_reg) begin
                        finish = 1'b1;
                    end
                end
            end
            default: begin
                if (accept) begin
                    state_next = ST_IDLE;
                    if (s_mqtt_mode) begin
                        if (s_rx_byte == CH_MARKER) begin
                            state_next = ST_GOT_MARK;
                        end
                    end else if (s_rx_byte == CH_O) begin
                        state_next = ST_GOT_O;
                    end
                end
            end
        endcase

        // frame complete: acks report now, publish walks the store
        if (finish) begin
            state_next = ST_IDLE;
            case (type_reg)
                T_CONNACK: begin
                    res_next     = single_event(EV_CONNACK);
                    m_valid_next = 1'b1;
                end
                T_PUBACK: begin
                    res_next     = single_event(EV_PUBACK);
                    m_valid_next = 1'b1;
                end
                T_SUBACK: begin
                    res_next     = single_event(EV_SUBACK);
                    m_valid_next = 1'b1;
                end
                T_PUBLISH: begin
                    state_next      = ST_REPLAY;
                    data_idx_next   = '0;
                    rd_pending_next = 1'b0;
                    last_idx_next   = AW'({1'b0, stored} + 9'd1);
                end
                default: begin
                end
            endcase
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_event_res = res_reg.event_res;
    assign m_data_byte = res_reg.data_byte;
    assign m_last      = res_reg.last;
    assign m_truncated = res_reg.truncated;

`ifndef ASSERT_OFF
    a_single_event_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_event_res != EV_PUB_BYTE) |->
            (m_last && m_data_byte == 8'h00 && !m_truncated))
        else $error("non-publish result carries payload fields");

    a_pending_only_in_replay: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_pending_reg |-> (state_reg == ST_REPLAY))
        else $error("store read pending outside replay");

    a_replay_index_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_REPLAY) |-> (data_idx_reg <= last_idx_reg))
        else $error("replay index ran past frame end");

    a_replay_ends_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_REPLAY) && $past(state_reg == ST_REPLAY) &&
         (state_next == ST_IDLE)) |-> (res_next.last && m_valid_next))
        else $error("replay left without a last byte");
`endif

endmodule
